/* rtl/core/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent assertions with and without a reset qualifier.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_RST(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define ASSERT_ALW(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define ASSERT_RST(lbl, clk, rst_n, prop)
`define ASSERT_ALW(lbl, clk, prop)
`endif
`endif

/* rtl/core/ste_pkg.sv */
// ----------------------------------------------------------------------------
// Sample table expander package
// Table depths, derived widths, operation and register codes, word types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ste_pkg;

    localparam int unsigned SAMPLE_DEPTH = 65536;
    localparam int unsigned RUN_DEPTH    = 4096;
    localparam int unsigned CHUNK_DEPTH  = 65536;

    localparam int unsigned SAMPLE_AW = $clog2(SAMPLE_DEPTH);
    localparam int unsigned SAMPLE_CW = SAMPLE_AW + 1;
    localparam int unsigned RUN_AW    = $clog2(RUN_DEPTH);
    localparam int unsigned RUN_CW    = RUN_AW + 1;
    localparam int unsigned CHUNK_AW  = $clog2(CHUNK_DEPTH);
    localparam int unsigned CHUNK_CW  = CHUNK_AW + 1;

    localparam int unsigned CFG_AW    = 5;
    localparam int unsigned DIV_STEPS = 64;
    localparam int unsigned DIV_CW    = $clog2(DIV_STEPS);

    localparam logic [29:0] NS_PER_SEC = 30'd1000000000;

    typedef enum logic [2:0] {
        OP_TIME_RUN,
        OP_OFFSET_RUN,
        OP_SYNC,
        OP_MAP_RUN,
        OP_CHUNK_OFF,
        OP_SIZE,
        OP_RESTART,
        OP_NEXT
    } t_op;

    typedef enum logic [2:0] {
        REG_TIMESCALE,
        REG_SAMPLE_TOTAL,
        REG_CONST_SIZE,
        REG_TIME_RUNS,
        REG_OFFSET_RUNS,
        REG_MAP_RUNS,
        REG_CHUNK_TOTAL,
        REG_SYNC_PRESENT
    } t_reg;

    typedef struct packed {
        t_op         operation;
        logic [15:0] entry_index;
        logic [31:0] run_length;
        logic [63:0] entry_value;
    } t_in_word;

    typedef struct packed {
        logic        sample_valid;
        logic [63:0] sample_offset;
        logic [31:0] sample_size;
        logic [63:0] pts_ns;
        logic        keyframe;
        logic        table_done;
    } t_out_word;

endpackage

/* rtl/core/sample_table_expander_unit.sv */
// ----------------------------------------------------------------------------
// Sample table expander unit
// Load words are written into the tables as they are taken and leave the unit
// idle. A next-sample word holds the input while the unit, if a sample is left,
// steps over empty chunks and passed map runs and, unless the time or the
// timescale is zero, computes the time by two 64-step serial divisions by the
// timescale; it also waits while the previous result word is unread. After
// reset all SAMPLE_DEPTH entries of the sync bitmap are cleared before the first
// word is taken; configuration writes are taken during that pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sample_table_expander_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  ste_pkg::t_in_word                i_in_data,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output ste_pkg::t_out_word               o_out_data,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [ste_pkg::CFG_AW-1:0]       paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_CHECK, S_WTEST, S_WMAP, S_WMAPCHK, S_WOFFWAIT,
        S_FREAD, S_FLOAD, S_FCOMP, S_DIV, S_M0, S_M1, S_M2, S_M3, S_FIN,
        S_UPDATE, S_LOOK, S_EMIT
    } t_state;

    t_state r_state;

    logic [31:0] r_timescale;
    logic [16:0] r_sample_total;
    logic [31:0] r_const_size;
    logic [12:0] r_time_run_total;
    logic [12:0] r_offset_run_total;
    logic [12:0] r_map_total;
    logic [16:0] r_chunk_total;
    logic        r_sync_present;

    logic [63:0]                   r_decode_ticks;
    logic [ste_pkg::RUN_CW-1:0]    r_time_cursor;
    logic [31:0]                   r_time_left;
    logic [31:0]                   r_time_delta;
    logic [ste_pkg::RUN_CW-1:0]    r_offset_cursor;
    logic [31:0]                   r_offset_left;
    logic [31:0]                   r_comp_offset;
    logic [ste_pkg::RUN_CW-1:0]    r_map_cursor;
    logic [31:0]                   r_per_chunk;
    logic [ste_pkg::CHUNK_CW-1:0]  r_chunk_number;
    logic [31:0]                   r_chunk_remaining;
    logic [63:0]                   r_running_offset;
    logic [ste_pkg::SAMPLE_CW-1:0] r_sample_cursor;

    logic [ste_pkg::CHUNK_CW-1:0]  r_w_num;
    logic [31:0]                   r_w_rem;
    logic [ste_pkg::RUN_CW-1:0]    r_w_mc;
    logic [31:0]                   r_w_pc;
    logic [63:0]                   r_w_off;
    logic                          r_commit;

    logic [ste_pkg::SAMPLE_AW-1:0] r_clr;
    logic [31:0]                   r_size;
    logic                          r_key;
    logic [63:0]                   r_dvd;
    logic [31:0]                   r_rem;
    logic [ste_pkg::DIV_CW-1:0]    r_div_cnt;
    logic                          r_second;
    logic [63:0]                   r_mul;
    logic [63:0]                   r_acc;
    logic [63:0]                   r_pts;
    ste_pkg::t_out_word            r_res;
    ste_pkg::t_out_word            r_out;
    logic                          r_out_valid;

    logic [63:0] tr_rd, or_rd, mr_rd, co_rd;
    logic [31:0] sz_rd;
    logic        sy_rd;

    logic in_acc, run_ok, chunk_ok, sample_ok, sync_ok;
    logic tr_we, or_we, mr_we, co_we, sz_we, sy_we;
    logic [ste_pkg::SAMPLE_AW-1:0] sy_wa;

    logic [ste_pkg::SAMPLE_CW-1:0] stot;
    logic [ste_pkg::RUN_CW-1:0]    ttot, otot, mtot;
    logic [ste_pkg::CHUNK_CW-1:0]  ctot;

    logic [63:0] mag, comp;
    logic [32:0] trial;
    logic        ge;
    logic [31:0] mul_a;
    logic [61:0] mul_p;
    logic [31:0] cur_size;

    assign in_acc     = i_in_valid && o_in_ready;
    assign o_in_ready = (r_state == S_IDLE);
    assign pready     = 1'b1;

    assign run_ok    = 32'(i_in_data.entry_index) < 32'(ste_pkg::RUN_DEPTH);
    assign chunk_ok  = 32'(i_in_data.entry_index) < 32'(ste_pkg::CHUNK_DEPTH);
    assign sample_ok = 32'(i_in_data.entry_index) < 32'(ste_pkg::SAMPLE_DEPTH);
    assign sync_ok   = (i_in_data.run_length != 32'd0)
                    && (i_in_data.run_length <= 32'(ste_pkg::SAMPLE_DEPTH));

    assign tr_we = in_acc && (i_in_data.operation == ste_pkg::OP_TIME_RUN) && run_ok;
    assign or_we = in_acc && (i_in_data.operation == ste_pkg::OP_OFFSET_RUN) && run_ok;
    assign mr_we = in_acc && (i_in_data.operation == ste_pkg::OP_MAP_RUN) && run_ok;
    assign co_we = in_acc && (i_in_data.operation == ste_pkg::OP_CHUNK_OFF) && chunk_ok;
    assign sz_we = in_acc && (i_in_data.operation == ste_pkg::OP_SIZE) && sample_ok;
    assign sy_we = (r_state == S_CLEAR)
                || (in_acc && (i_in_data.operation == ste_pkg::OP_SYNC) && sync_ok);
    assign sy_wa = (r_state == S_CLEAR) ? r_clr
                 : ste_pkg::SAMPLE_AW'(i_in_data.run_length - 32'd1);

    ste_ram #(.WIDTH(64), .DEPTH(ste_pkg::RUN_DEPTH)) u_time_runs (
        .i_clk(i_clk), .i_we(tr_we),
        .i_waddr(ste_pkg::RUN_AW'(i_in_data.entry_index)),
        .i_wdata({i_in_data.run_length, i_in_data.entry_value[31:0]}),
        .i_raddr(ste_pkg::RUN_AW'(r_time_cursor)), .o_rdata(tr_rd)
    );

    ste_ram #(.WIDTH(64), .DEPTH(ste_pkg::RUN_DEPTH)) u_offset_runs (
        .i_clk(i_clk), .i_we(or_we),
        .i_waddr(ste_pkg::RUN_AW'(i_in_data.entry_index)),
        .i_wdata({i_in_data.run_length, i_in_data.entry_value[31:0]}),
        .i_raddr(ste_pkg::RUN_AW'(r_offset_cursor)), .o_rdata(or_rd)
    );

    ste_ram #(.WIDTH(64), .DEPTH(ste_pkg::RUN_DEPTH)) u_map_runs (
        .i_clk(i_clk), .i_we(mr_we),
        .i_waddr(ste_pkg::RUN_AW'(i_in_data.entry_index)),
        .i_wdata({i_in_data.run_length, i_in_data.entry_value[31:0]}),
        .i_raddr(ste_pkg::RUN_AW'(r_w_mc)), .o_rdata(mr_rd)
    );

    ste_ram #(.WIDTH(64), .DEPTH(ste_pkg::CHUNK_DEPTH)) u_chunk_offsets (
        .i_clk(i_clk), .i_we(co_we),
        .i_waddr(ste_pkg::CHUNK_AW'(i_in_data.entry_index)),
        .i_wdata(i_in_data.entry_value),
        .i_raddr(ste_pkg::CHUNK_AW'(r_w_num - ste_pkg::CHUNK_CW'(1))),
        .o_rdata(co_rd)
    );

    ste_ram #(.WIDTH(32), .DEPTH(ste_pkg::SAMPLE_DEPTH)) u_sample_sizes (
        .i_clk(i_clk), .i_we(sz_we),
        .i_waddr(ste_pkg::SAMPLE_AW'(i_in_data.entry_index)),
        .i_wdata(i_in_data.entry_value[31:0]),
        .i_raddr(ste_pkg::SAMPLE_AW'(r_sample_cursor)), .o_rdata(sz_rd)
    );

    ste_ram #(.WIDTH(1), .DEPTH(ste_pkg::SAMPLE_DEPTH)) u_sync_bitmap (
        .i_clk(i_clk), .i_we(sy_we), .i_waddr(sy_wa),
        .i_wdata(r_state != S_CLEAR),
        .i_raddr(ste_pkg::SAMPLE_AW'(r_sample_cursor)), .o_rdata(sy_rd)
    );

    always_comb begin
        stot = (32'(r_sample_total) >= 32'(ste_pkg::SAMPLE_DEPTH))
             ? ste_pkg::SAMPLE_CW'(ste_pkg::SAMPLE_DEPTH)
             : ste_pkg::SAMPLE_CW'(r_sample_total);
        ttot = (32'(r_time_run_total) >= 32'(ste_pkg::RUN_DEPTH))
             ? ste_pkg::RUN_CW'(ste_pkg::RUN_DEPTH) : ste_pkg::RUN_CW'(r_time_run_total);
        otot = (32'(r_offset_run_total) >= 32'(ste_pkg::RUN_DEPTH))
             ? ste_pkg::RUN_CW'(ste_pkg::RUN_DEPTH) : ste_pkg::RUN_CW'(r_offset_run_total);
        mtot = (32'(r_map_total) >= 32'(ste_pkg::RUN_DEPTH))
             ? ste_pkg::RUN_CW'(ste_pkg::RUN_DEPTH) : ste_pkg::RUN_CW'(r_map_total);
        ctot = (32'(r_chunk_total) >= 32'(ste_pkg::CHUNK_DEPTH))
             ? ste_pkg::CHUNK_CW'(ste_pkg::CHUNK_DEPTH) : ste_pkg::CHUNK_CW'(r_chunk_total);

        mag = {32'd0, 32'(~r_comp_offset + 32'd1)};
        if (r_comp_offset[31]) begin
            comp = (r_decode_ticks > mag) ? (r_decode_ticks - mag) : 64'd0;
        end else begin
            comp = r_decode_ticks + {32'd0, r_comp_offset};
        end

        trial = {r_rem, r_dvd[63]};
        ge    = trial >= {1'b0, r_timescale};

        case (r_state)
            S_M0:    mul_a = r_dvd[31:0];
            S_M1:    mul_a = r_dvd[63:32];
            default: mul_a = r_rem;
        endcase
        mul_p = 62'(mul_a) * 62'(ste_pkg::NS_PER_SEC);

        cur_size = (r_const_size != 32'd0) ? r_const_size : sz_rd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timescale        <= '0;
            r_sample_total     <= '0;
            r_const_size       <= '0;
            r_time_run_total   <= '0;
            r_offset_run_total <= '0;
            r_map_total        <= '0;
            r_chunk_total      <= '0;
            r_sync_present     <= 1'b0;
        end else if (psel && penable && pwrite) begin
            case (ste_pkg::t_reg'(paddr[ste_pkg::CFG_AW-1:2]))
                ste_pkg::REG_TIMESCALE:    r_timescale        <= pwdata;
                ste_pkg::REG_SAMPLE_TOTAL: r_sample_total     <= pwdata[16:0];
                ste_pkg::REG_CONST_SIZE:   r_const_size       <= pwdata;
                ste_pkg::REG_TIME_RUNS:    r_time_run_total   <= pwdata[12:0];
                ste_pkg::REG_OFFSET_RUNS:  r_offset_run_total <= pwdata[12:0];
                ste_pkg::REG_MAP_RUNS:     r_map_total        <= pwdata[12:0];
                ste_pkg::REG_CHUNK_TOTAL:  r_chunk_total      <= pwdata[16:0];
                ste_pkg::REG_SYNC_PRESENT: r_sync_present     <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (ste_pkg::t_reg'(paddr[ste_pkg::CFG_AW-1:2]))
            ste_pkg::REG_TIMESCALE:    prdata = r_timescale;
            ste_pkg::REG_SAMPLE_TOTAL: prdata = 32'(r_sample_total);
            ste_pkg::REG_CONST_SIZE:   prdata = r_const_size;
            ste_pkg::REG_TIME_RUNS:    prdata = 32'(r_time_run_total);
            ste_pkg::REG_OFFSET_RUNS:  prdata = 32'(r_offset_run_total);
            ste_pkg::REG_MAP_RUNS:     prdata = 32'(r_map_total);
            ste_pkg::REG_CHUNK_TOTAL:  prdata = 32'(r_chunk_total);
            ste_pkg::REG_SYNC_PRESENT: prdata = 32'(r_sync_present);
            default:                   prdata = 32'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state           <= S_CLEAR;
            r_clr             <= '0;
            r_out_valid       <= 1'b0;
            r_decode_ticks    <= '0;
            r_time_cursor     <= '0;
            r_time_left       <= '0;
            r_time_delta      <= '0;
            r_offset_cursor   <= '0;
            r_offset_left     <= '0;
            r_comp_offset     <= '0;
            r_map_cursor      <= '0;
            r_per_chunk       <= 32'd1;
            r_chunk_number    <= '0;
            r_chunk_remaining <= '0;
            r_running_offset  <= '0;
            r_sample_cursor   <= '0;
            r_commit          <= 1'b0;
            r_second          <= 1'b0;
            r_div_cnt         <= '0;
        end else begin
            if (r_out_valid && i_out_ready && r_state != S_EMIT) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + ste_pkg::SAMPLE_AW'(1);
                    if (r_clr == ste_pkg::SAMPLE_AW'(ste_pkg::SAMPLE_DEPTH - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (in_acc) begin
                        case (i_in_data.operation)
                            ste_pkg::OP_RESTART: begin
                                r_decode_ticks    <= '0;
                                r_time_cursor     <= '0;
                                r_time_left       <= '0;
                                r_time_delta      <= '0;
                                r_offset_cursor   <= '0;
                                r_offset_left     <= '0;
                                r_comp_offset     <= '0;
                                r_map_cursor      <= '0;
                                r_per_chunk       <= 32'd1;
                                r_chunk_number    <= '0;
                                r_chunk_remaining <= '0;
                                r_running_offset  <= '0;
                                r_sample_cursor   <= '0;
                            end
                            ste_pkg::OP_NEXT: r_state <= S_CHECK;
                            default: ;
                        endcase
                    end
                end
                S_CHECK: begin
                    r_w_num  <= r_chunk_number;
                    r_w_rem  <= r_chunk_remaining;
                    r_w_mc   <= r_map_cursor;
                    r_w_pc   <= r_per_chunk;
                    r_w_off  <= r_running_offset;
                    r_commit <= 1'b1;
                    if (r_sample_cursor >= stot) begin
                        r_res   <= '{default: '0, table_done: 1'b1};
                        r_state <= S_EMIT;
                    end else begin
                        r_state <= S_WTEST;
                    end
                end
                S_WTEST: begin
                    if (r_w_rem != 32'd0 || r_w_num >= ctot) begin
                        if (!r_commit) begin
                            r_res.table_done <= (r_w_rem == 32'd0);
                            r_state          <= S_EMIT;
                        end else if (r_w_rem != 32'd0) begin
                            r_chunk_number    <= r_w_num;
                            r_chunk_remaining <= r_w_rem;
                            r_map_cursor      <= r_w_mc;
                            r_per_chunk       <= r_w_pc;
                            r_running_offset  <= r_w_off;
                            r_state           <= S_FREAD;
                        end else begin
                            r_res   <= '{default: '0, table_done: 1'b1};
                            r_state <= S_EMIT;
                        end
                    end else begin
                        r_w_num <= r_w_num + ste_pkg::CHUNK_CW'(1);
                        r_state <= S_WMAP;
                    end
                end
                S_WMAP: begin
                    r_state <= (r_w_mc < mtot) ? S_WMAPCHK : S_WOFFWAIT;
                end
                S_WMAPCHK: begin
                    if (mr_rd[63:32] <= 32'(r_w_num)) begin
                        r_w_pc  <= mr_rd[31:0];
                        r_w_mc  <= r_w_mc + ste_pkg::RUN_CW'(1);
                        r_state <= S_WMAP;
                    end else begin
                        r_state <= S_WOFFWAIT;
                    end
                end
                S_WOFFWAIT: begin
                    r_w_off <= co_rd;
                    r_w_rem <= r_w_pc;
                    r_state <= S_WTEST;
                end
                S_FREAD: r_state <= S_FLOAD;
                S_FLOAD: begin
                    r_size <= cur_size;
                    r_key  <= r_sync_present ? sy_rd : 1'b1;
                    if (r_time_left == 32'd0 && r_time_cursor < ttot) begin
                        r_time_left   <= tr_rd[63:32];
                        r_time_delta  <= tr_rd[31:0];
                        r_time_cursor <= r_time_cursor + ste_pkg::RUN_CW'(1);
                    end
                    if (r_offset_left == 32'd0 && r_offset_cursor < otot) begin
                        r_offset_left   <= or_rd[63:32];
                        r_comp_offset   <= or_rd[31:0];
                        r_offset_cursor <= r_offset_cursor + ste_pkg::RUN_CW'(1);
                    end
                    r_state <= S_FCOMP;
                end
                S_FCOMP: begin
                    if (comp == 64'd0 || r_timescale == 32'd0) begin
                        r_pts   <= '0;
                        r_state <= S_UPDATE;
                    end else begin
                        r_dvd     <= comp;
                        r_rem     <= '0;
                        r_div_cnt <= '0;
                        r_second  <= 1'b0;
                        r_state   <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_rem     <= ge ? 32'(trial - {1'b0, r_timescale}) : trial[31:0];
                    r_dvd     <= {r_dvd[62:0], ge};
                    r_div_cnt <= r_div_cnt + ste_pkg::DIV_CW'(1);
                    if (r_div_cnt == ste_pkg::DIV_CW'(ste_pkg::DIV_STEPS - 1)) begin
                        r_state <= r_second ? S_FIN : S_M0;
                    end
                end
                S_M0: begin
                    r_mul   <= 64'(mul_p);
                    r_state <= S_M1;
                end
                S_M1: begin
                    r_acc   <= r_mul;
                    r_mul   <= 64'(mul_p);
                    r_state <= S_M2;
                end
                S_M2: begin
                    r_acc   <= r_acc + {r_mul[31:0], 32'd0};
                    r_mul   <= 64'(mul_p);
                    r_state <= S_M3;
                end
                S_M3: begin
                    r_dvd     <= r_mul;
                    r_rem     <= '0;
                    r_div_cnt <= '0;
                    r_second  <= 1'b1;
                    r_state   <= S_DIV;
                end
                S_FIN: begin
                    r_pts   <= r_acc + r_dvd;
                    r_state <= S_UPDATE;
                end
                S_UPDATE: begin
                    r_res <= '{sample_valid: 1'b1, sample_offset: r_running_offset,
                               sample_size: r_size, pts_ns: r_pts, keyframe: r_key,
                               table_done: 1'b0};
                    if (r_time_left != 32'd0) begin
                        r_decode_ticks <= r_decode_ticks + {32'd0, r_time_delta};
                        r_time_left    <= r_time_left - 32'd1;
                    end
                    if (r_offset_left != 32'd0) begin
                        r_offset_left <= r_offset_left - 32'd1;
                    end
                    r_running_offset  <= r_running_offset + {32'd0, r_size};
                    r_chunk_remaining <= r_chunk_remaining - 32'd1;
                    r_sample_cursor   <= r_sample_cursor + ste_pkg::SAMPLE_CW'(1);
                    r_state           <= S_LOOK;
                end
                S_LOOK: begin
                    r_w_num  <= r_chunk_number;
                    r_w_rem  <= r_chunk_remaining;
                    r_w_mc   <= r_map_cursor;
                    r_w_pc   <= r_per_chunk;
                    r_w_off  <= r_running_offset;
                    r_commit <= 1'b0;
                    if (r_sample_cursor >= stot) begin
                        r_res.table_done <= 1'b1;
                        r_state          <= S_EMIT;
                    end else begin
                        r_state <= S_WTEST;
                    end
                end
                S_EMIT: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out       <= r_res;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `ASSERT_RST(a_empty_form, i_clk, i_rst_n, o_out_valid && !o_out_data.sample_valid |-> o_out_data.table_done && o_out_data.pts_ns == 64'd0 && !o_out_data.keyframe)
    `ASSERT_RST(a_zero_scale, i_clk, i_rst_n, o_out_valid && r_timescale == 32'd0 |-> o_out_data.pts_ns == 64'd0)
    `ASSERT_ALW(a_clear_busy, i_clk, r_state == S_CLEAR |-> !o_in_ready && sy_we)

endmodule

/* rtl/core/ste_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ste_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* bench/sample_table_expander_unit_test.sv */
// ----------------------------------------------------------------------------
// Sample table expander unit testbench
// Loads sample tables over the input channel, sets the track registers over
// the configuration port and steps through samples. Every result word is
// checked against a predictor of the expansion, under random input gaps and
// output stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sample_table_expander_unit_test;

    localparam int unsigned WATCHDOG_LIMIT = 250000;
    localparam int unsigned SETTLE_CYCLES  = 800;
    localparam int unsigned HOLD_CYCLES    = 3000;
    localparam int unsigned FILL_DEPTH     = 64;
    localparam int unsigned NEXT_BUDGET    = 56;
    localparam int unsigned PHASES         = 14;
    localparam int unsigned PHASE_WORDS    = 80;

    localparam ste_pkg::t_out_word NO_SAMPLE = '{sample_valid: 1'b0, sample_offset: 64'd0,
        sample_size: 32'd0, pts_ns: 64'd0, keyframe: 1'b0, table_done: 1'b1};

    typedef struct {
        ste_pkg::t_op       op;
        logic [15:0]        idx;
        logic [31:0]        len;
        logic [63:0]        val;
        bit                 typed;
        ste_pkg::t_out_word outcome;
    } t_script_row;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    ste_pkg::t_in_word  i_in_data = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    ste_pkg::t_out_word o_out_data;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [ste_pkg::CFG_AW-1:0] paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;

    // Track registers as the block should hold them.
    logic [31:0] cfg_timescale, cfg_const_size;
    logic [16:0] cfg_samples, cfg_chunks;
    logic [12:0] cfg_time_runs, cfg_offset_runs, cfg_map_runs;
    logic        cfg_sync;

    logic [63:0] tbl_time [0:ste_pkg::RUN_DEPTH-1];
    logic [63:0] tbl_offset [0:ste_pkg::RUN_DEPTH-1];
    logic [63:0] tbl_map [0:ste_pkg::RUN_DEPTH-1];
    logic [63:0] tbl_chunk [0:ste_pkg::CHUNK_DEPTH-1];
    logic [31:0] tbl_size [0:ste_pkg::SAMPLE_DEPTH-1];
    bit          tbl_sync [0:ste_pkg::SAMPLE_DEPTH-1];

    logic [63:0] dts, run_off;
    logic [31:0] t_pos, t_left, t_delta, o_pos, o_left, c_off;
    logic [31:0] map_pos, per_chunk_n, chunk_num, chunk_left, cur_sample;

    ste_pkg::t_out_word descriptors_due [$];
    t_script_row script [11];
    int unsigned mismatches = 0;
    int unsigned words_in = 0;
    int unsigned descriptors_out = 0;
    int unsigned burst_left = 0;
    int unsigned idle_cycles = 0;
    int unsigned hold_asked = 0;
    int unsigned hold_seen = 0;
    int unsigned hold_left = 0;
    int unsigned stall_mode = 0;
    int unsigned mode_left = 0;
    int unsigned nexts_since_restart = 0;

    sample_table_expander_unit uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out_data(o_out_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic logic [63:0] saturate(logic [63:0] v, logic [63:0] depth);
        return (v < depth) ? v : depth;
    endfunction

    function automatic logic [63:0] ticks_to_nanos(logic [63:0] t);
        logic [63:0] ts;
        ts = {32'd0, cfg_timescale};
        if (ts == 64'd0) return 64'd0;
        return (t / ts) * 64'd1000000000 + ((t % ts) * 64'd1000000000) / ts;
    endfunction

    // Walks forward to a chunk with a sample left; updates state only on commit.
    function automatic bit locate_chunk(bit commit);
        logic [31:0] num, rem, mc, pc;
        logic [63:0] off, ctot, mtot;
        num = chunk_num; rem = chunk_left; mc = map_pos; pc = per_chunk_n; off = run_off;
        ctot = saturate(64'(cfg_chunks), 64'(ste_pkg::CHUNK_DEPTH));
        mtot = saturate(64'(cfg_map_runs), 64'(ste_pkg::RUN_DEPTH));
        while (rem == 0) begin
            if (num >= ctot) return 1'b0;
            num++;
            while (mc < mtot && tbl_map[mc][63:32] <= num) begin
                pc = tbl_map[mc][31:0];
                mc++;
            end
            off = tbl_chunk[num - 1];
            rem = pc;
        end
        if (commit) begin
            chunk_num = num; chunk_left = rem; map_pos = mc;
            per_chunk_n = pc; run_off = off;
        end
        return 1'b1;
    endfunction

    function automatic void rewind_track();
        dts = '0; t_pos = '0; t_left = '0; t_delta = '0;
        o_pos = '0; o_left = '0; c_off = '0;
        map_pos = '0; per_chunk_n = 32'd1; chunk_num = '0; chunk_left = '0;
        run_off = '0; cur_sample = '0;
    endfunction

    function automatic void expand_word(ste_pkg::t_in_word w);
        ste_pkg::t_out_word d;
        logic [63:0] sz, comp, mag, lim;
        logic [31:0] neg;
        d = '0;
        lim = saturate(64'(cfg_samples), 64'(ste_pkg::SAMPLE_DEPTH));
        case (w.operation)
            ste_pkg::OP_TIME_RUN: begin
                if (w.entry_index < ste_pkg::RUN_DEPTH)
                    tbl_time[w.entry_index] = {w.run_length, w.entry_value[31:0]};
            end
            ste_pkg::OP_OFFSET_RUN: begin
                if (w.entry_index < ste_pkg::RUN_DEPTH)
                    tbl_offset[w.entry_index] = {w.run_length, w.entry_value[31:0]};
            end
            ste_pkg::OP_SYNC: begin
                if (w.run_length >= 1 && w.run_length <= ste_pkg::SAMPLE_DEPTH)
                    tbl_sync[w.run_length - 1] = 1'b1;
            end
            ste_pkg::OP_MAP_RUN: begin
                if (w.entry_index < ste_pkg::RUN_DEPTH)
                    tbl_map[w.entry_index] = {w.run_length, w.entry_value[31:0]};
            end
            ste_pkg::OP_CHUNK_OFF: begin
                if (w.entry_index < ste_pkg::CHUNK_DEPTH)
                    tbl_chunk[w.entry_index] = w.entry_value;
            end
            ste_pkg::OP_SIZE: begin
                if (w.entry_index < ste_pkg::SAMPLE_DEPTH)
                    tbl_size[w.entry_index] = w.entry_value[31:0];
            end
            ste_pkg::OP_RESTART: rewind_track();
            ste_pkg::OP_NEXT: begin
                if (64'(cur_sample) >= lim || !locate_chunk(1'b1)) begin
                    d = NO_SAMPLE;
                end else begin
                    sz = (cfg_const_size != 0) ? {32'd0, cfg_const_size}
                                               : {32'd0, tbl_size[cur_sample]};
                    if (t_left == 0 && 64'(t_pos) < saturate(64'(cfg_time_runs),
                        64'(ste_pkg::RUN_DEPTH))) begin
                        t_left = tbl_time[t_pos][63:32];
                        t_delta = tbl_time[t_pos][31:0];
                        t_pos++;
                    end
                    if (o_left == 0 && 64'(o_pos) < saturate(64'(cfg_offset_runs),
                        64'(ste_pkg::RUN_DEPTH))) begin
                        o_left = tbl_offset[o_pos][63:32];
                        c_off = tbl_offset[o_pos][31:0];
                        o_pos++;
                    end
                    if (c_off[31]) begin
                        neg = ~c_off + 32'd1;
                        mag = {32'd0, neg};
                        if (mag == 64'd0) mag = 64'h8000_0000;
                        comp = (dts > mag) ? dts - mag : 64'd0;
                    end else begin
                        comp = dts + {32'd0, c_off};
                    end
                    d.sample_valid = 1'b1;
                    d.sample_offset = run_off;
                    d.sample_size = sz[31:0];
                    d.pts_ns = (comp != 64'd0) ? ticks_to_nanos(comp) : 64'd0;
                    d.keyframe = cfg_sync ? tbl_sync[cur_sample] : 1'b1;
                    if (t_left != 0) begin
                        dts = dts + {32'd0, t_delta};
                        t_left--;
                    end
                    if (o_left != 0) o_left--;
                    run_off = run_off + sz;
                    chunk_left--;
                    cur_sample++;
                    d.table_done = (64'(cur_sample) >= lim) || !locate_chunk(1'b0);
                end
                descriptors_due.push_back(d);
            end
            default: ;
        endcase
    endfunction

    task automatic send_word(ste_pkg::t_in_word w);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 1) ? $urandom_range(1, 12) : 0;
            burst_left = $urandom_range(1, 40);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_in_data <= w;
        do @(posedge i_clk); while (!o_in_ready);
        words_in++;
        expand_word(w);
    endtask

    task automatic send_fields(ste_pkg::t_op op, logic [15:0] idx, logic [31:0] len,
        logic [63:0] val);
        ste_pkg::t_in_word w;
        w.operation = op; w.entry_index = idx; w.run_length = len; w.entry_value = val;
        send_word(w);
        if (op == ste_pkg::OP_RESTART) nexts_since_restart = 0;
        if (op == ste_pkg::OP_NEXT) nexts_since_restart++;
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        while (descriptors_due.size() > 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(ste_pkg::t_reg r, logic [31:0] v);
        @(posedge i_clk);
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
        paddr <= {r, 2'b00}; pwdata <= v;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (r)
            ste_pkg::REG_TIMESCALE:    cfg_timescale = v;
            ste_pkg::REG_SAMPLE_TOTAL: cfg_samples = v[16:0];
            ste_pkg::REG_CONST_SIZE:   cfg_const_size = v;
            ste_pkg::REG_TIME_RUNS:    cfg_time_runs = v[12:0];
            ste_pkg::REG_OFFSET_RUNS:  cfg_offset_runs = v[12:0];
            ste_pkg::REG_MAP_RUNS:     cfg_map_runs = v[12:0];
            ste_pkg::REG_CHUNK_TOTAL:  cfg_chunks = v[16:0];
            ste_pkg::REG_SYNC_PRESENT: cfg_sync = v[0];
            default: ;
        endcase
    endtask

    task automatic configure(int unsigned p);
        logic [31:0] v [8];
        case (p)
            0: v = '{32'd1000, 32'd20, 32'd0, 32'd3, 32'd2, 32'd2, 32'd10, 32'd1};
            1: v = '{32'hFFFF_FFFF, 32'd65536, 32'hFFFF_FFFF, 32'd4096, 32'd4096,
                     32'd4096, 32'd64, 32'd0};
            2: v = '{32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd65536, 32'd1};
            3: v = '{32'd1, 32'd1, 32'd0, 32'd1, 32'd0, 32'd1, 32'd1, 32'd0};
            default: begin
                v[0] = $urandom_range(0, 2) == 0 ? $urandom : ($urandom_range(0, 1) ?
                       32'd90000 : 32'd1);
                v[1] = $urandom_range(0, 70);
                v[2] = $urandom_range(0, 1) ? 32'd0 : $urandom;
                v[3] = $urandom_range(0, 70);
                v[4] = $urandom_range(0, 70);
                v[5] = $urandom_range(0, 64);
                v[6] = $urandom_range(0, 64);
                v[7] = $urandom_range(0, 1);
            end
        endcase
        for (int r = 0; r < 8; r++) cfg_write(ste_pkg::t_reg'(r), v[r]);
    endtask

    task automatic random_word();
        int unsigned pick;
        logic [15:0] small_idx;
        pick = $urandom_range(0, 99);
        small_idx = 16'($urandom_range(0, FILL_DEPTH - 2));
        if (pick < 55) begin
            if (nexts_since_restart < NEXT_BUDGET)
                send_fields(ste_pkg::OP_NEXT, 16'($urandom), $urandom,
                    {$urandom, $urandom});
            else send_fields(ste_pkg::OP_RESTART, 16'($urandom), $urandom,
                {$urandom, $urandom});
        end else if (pick < 63) begin
            send_fields(ste_pkg::OP_TIME_RUN, small_idx, $urandom_range(0, 1) ?
                $urandom_range(0, 4) : $urandom,
                {$urandom, $urandom_range(0, 1) ? $urandom : $urandom_range(0, 3000)});
        end else if (pick < 69) begin
            send_fields(ste_pkg::OP_OFFSET_RUN, small_idx, $urandom_range(0, 5),
                {$urandom, $urandom});
        end else if (pick < 73) begin
            send_fields(ste_pkg::OP_MAP_RUN, small_idx, $urandom_range(1, 40),
                {$urandom, 32'(int'($urandom_range(0, 4)))});
        end else if (pick < 78) begin
            send_fields(ste_pkg::OP_CHUNK_OFF, $urandom_range(0, 1) ? small_idx
                : 16'($urandom), $urandom, {$urandom, $urandom});
        end else if (pick < 84) begin
            send_fields(ste_pkg::OP_SIZE, $urandom_range(0, 1) ? small_idx
                : 16'($urandom), $urandom, {$urandom, $urandom});
        end else if (pick < 90) begin
            send_fields(ste_pkg::OP_SYNC, 16'($urandom), $urandom_range(0, 3) == 0 ?
                $urandom : $urandom_range(0, 64), {$urandom, $urandom});
        end else if (pick < 94) begin
            send_fields(ste_pkg::OP_RESTART, 16'($urandom), $urandom,
                {$urandom, $urandom});
        end else begin
            send_fields(ste_pkg::t_op'($urandom_range(0, 1) ? ste_pkg::OP_TIME_RUN
                : ste_pkg::OP_OFFSET_RUN),
                16'($urandom_range(ste_pkg::RUN_DEPTH, 65535)), $urandom,
                {$urandom, $urandom});
        end
    endtask

    always @(posedge i_clk) begin
        if (hold_asked != hold_seen) begin
            hold_seen = hold_asked;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                stall_mode = $urandom_range(0, 2);
                mode_left = $urandom_range(20, 300);
            end
            mode_left--;
            case (stall_mode)
                0: i_out_ready <= 1'b1;
                1: i_out_ready <= ($urandom_range(0, 3) != 0);
                default: i_out_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    always @(posedge i_clk) begin
        ste_pkg::t_out_word e;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            descriptors_out++;
            if (descriptors_due.size() == 0) begin
                $error("unexpected result word %h", o_out_data);
                mismatches++;
            end else begin
                e = descriptors_due.pop_front();
                if (o_out_data.sample_valid !== e.sample_valid) begin
                    $error("sample_valid: expected %0d, got %0d", e.sample_valid,
                        o_out_data.sample_valid);
                    mismatches++;
                end
                if (o_out_data.sample_offset !== e.sample_offset) begin
                    $error("sample_offset: expected %0h, got %0h", e.sample_offset,
                        o_out_data.sample_offset);
                    mismatches++;
                end
                if (o_out_data.sample_size !== e.sample_size) begin
                    $error("sample_size: expected %0h, got %0h", e.sample_size,
                        o_out_data.sample_size);
                    mismatches++;
                end
                if (o_out_data.pts_ns !== e.pts_ns) begin
                    $error("pts_ns: expected %0d, got %0d", e.pts_ns, o_out_data.pts_ns);
                    mismatches++;
                end
                if (o_out_data.keyframe !== e.keyframe) begin
                    $error("keyframe: expected %0d, got %0d", e.keyframe, o_out_data.keyframe);
                    mismatches++;
                end
                if (o_out_data.table_done !== e.table_done) begin
                    $error("table_done: expected %0d, got %0d", e.table_done,
                        o_out_data.table_done);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || psel)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("sample_table_expander_unit: mismatch");
            $finish;
        end
    end

    initial begin
        cfg_timescale = '0; cfg_samples = '0; cfg_const_size = '0; cfg_time_runs = '0;
        cfg_offset_runs = '0; cfg_map_runs = '0; cfg_chunks = '0; cfg_sync = 1'b0;
        rewind_track();
        script = '{
            '{ste_pkg::OP_NEXT,       16'd0,    32'd0,         64'd0, 1'b1, NO_SAMPLE},
            '{ste_pkg::OP_SYNC,       16'hFFFF, 32'd0,         64'd0, 1'b0, NO_SAMPLE},
            '{ste_pkg::OP_SYNC,       16'd0,    32'd65536,     64'd0, 1'b0, NO_SAMPLE},
            '{ste_pkg::OP_SYNC,       16'd0,    32'hFFFF_FFFF, '1,    1'b0, NO_SAMPLE},
            '{ste_pkg::OP_SYNC,       16'd0,    32'd1,         64'd0, 1'b0, NO_SAMPLE},
            '{ste_pkg::OP_TIME_RUN,   16'hFFFF, 32'hFFFF_FFFF, '1,    1'b0, NO_SAMPLE},
            '{ste_pkg::OP_OFFSET_RUN, 16'd4096, 32'd7,         '1,    1'b0, NO_SAMPLE},
            '{ste_pkg::OP_CHUNK_OFF,  16'hFFFF, 32'd0,         '1,    1'b0, NO_SAMPLE},
            '{ste_pkg::OP_SIZE,       16'hFFFF, 32'd0,         '1,    1'b0, NO_SAMPLE},
            '{ste_pkg::OP_RESTART,    16'd0,    32'd0,         64'd0, 1'b0, NO_SAMPLE},
            '{ste_pkg::OP_NEXT,       16'hFFFF, 32'hFFFF_FFFF, '1,    1'b1, NO_SAMPLE}
        };
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (script[i]) begin
            send_fields(script[i].op, script[i].idx, script[i].len, script[i].val);
            if (script[i].typed)
                descriptors_due[descriptors_due.size() - 1] = script[i].outcome;
        end

        // Every entry that a track can reach is written before any sample is read.
        for (int i = 0; i < FILL_DEPTH; i++) begin
            send_fields(ste_pkg::OP_TIME_RUN, 16'(i), $urandom_range(0, 3),
                {32'd0, $urandom_range(0, 5000)});
            send_fields(ste_pkg::OP_OFFSET_RUN, 16'(i), $urandom_range(0, 3),
                {32'd0, $urandom_range(0, 1) ? 32'($urandom_range(0, 4000))
                : -32'($urandom_range(1, 4000))});
            send_fields(ste_pkg::OP_MAP_RUN, 16'(i), (i == FILL_DEPTH - 1) ? 32'hFFFF_FFFF
                : $urandom_range(1, 40), {32'd0, 32'(int'($urandom_range(0, 4)))});
            send_fields(ste_pkg::OP_CHUNK_OFF, 16'(i), 32'd0, {$urandom, $urandom});
            send_fields(ste_pkg::OP_SIZE, 16'(i), 32'd0, {32'd0, $urandom});
        end

        for (int p = 0; p < PHASES; p++) begin
            settle();
            configure(p);
            send_fields(ste_pkg::OP_RESTART, 16'd0, 32'd0, 64'd0);
            if (p == 5) hold_asked++;
            for (int n = 0; n < PHASE_WORDS; n++) random_word();
        end
        settle();

        $display("Sent %0d input words over %0d register settings; checked %0d result words.",
            words_in, PHASES + 1, descriptors_out);
        if (mismatches == 0 && descriptors_due.size() == 0) begin
            $display("sample_table_expander_unit: match");
        end else begin
            $display("sample_table_expander_unit: mismatch");
        end
        $finish;
    end

endmodule

/* files.f */
+incdir+rtl/core
rtl/core/ste_pkg.sv
rtl/core/ste_ram.sv
rtl/core/sample_table_expander_unit.sv
bench/sample_table_expander_unit_test.sv
